>>> design/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the stereo linear resampler
// Sample and fraction widths, the position format and the job record
// that the front end hands to the interpolation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 24;

  // The position stays below 1.0 + largest step, so one bit over the step fits.
  localparam int POS_W  = STEP_W + 1;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

  localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 6);
  localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_RESET = ONE_STEP;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic    prime;
    sample_t left;
    sample_t right;
  } slr_job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_EMIT = 3'b100
  } slr_state_t;

endpackage

`default_nettype wire

>>> design/slr_front.sv
// ----------------------------------------------------------------------------
// slr_front: input acceptance and job queue
// Accepts stereo frames, marks the first one after reset as a priming
// frame and holds up to two jobs for the interpolation engine.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_front
  import slr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [2*SAMPLE_BITS-1:0] s_axis_tdata,  // left_in, right_in
  output logic                          job_valid,
  output slr_job_t                      job,
  input  wire logic                     job_pop
);

  slr_job_t   queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       primed;
  logic       push;

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign job_valid     = (count != 2'd0);
  assign job           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].prime <= !primed;
      queue[wr_ptr].left  <= s_axis_tdata[SAMPLE_BITS-1:0];
      queue[wr_ptr].right <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      primed <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
        primed <= 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, job_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/slr_back.sv
// ----------------------------------------------------------------------------
// slr_back: interpolation engine
// Keeps the previous frame and the read position, and emits interpolated
// stereo samples through an output register, holding while it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_back
  import slr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [STEP_W-1:0]        step,
  input  wire logic                     job_valid,
  input  wire slr_job_t                 job,
  output logic                          job_pop,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [2*SAMPLE_BITS-1:0]      m_axis_tdata,  // left_out, right_out
  output logic                          m_axis_tlast   // last_of_run
);

  slr_state_t               state;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_sum;
  sample_t                  prev_l;
  sample_t                  prev_r;
  sample_t                  cur_l;
  sample_t                  cur_r;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic                     last;
  logic                     load_out;
  logic signed [PROD_W-1:0] shift_l;
  logic signed [PROD_W-1:0] shift_r;
  logic [DIFF_W-1:0]        sum_l;
  logic [DIFF_W-1:0]        sum_r;
  sample_t                  out_l;
  sample_t                  out_r;
  logic                     pos_ge_one;

  assign pos_ge_one = (pos >= ONE_POS);
  assign pos_sum    = pos + POS_W'(step);
  assign job_pop    = (state == ST_IDLE) && job_valid;
  assign load_out   = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Arithmetic right shift gives the floor of the scaled difference.
  assign shift_l = prod_l >>> FRAC_BITS;
  assign shift_r = prod_r >>> FRAC_BITS;
  assign sum_l   = DIFF_W'(prev_l) + shift_l[DIFF_W-1:0];
  assign sum_r   = DIFF_W'(prev_r) + shift_r[DIFF_W-1:0];

  assign m_axis_tdata = {out_r, out_l};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= '0;
      prev_l        <= '0;
      prev_r        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= load_out || (m_axis_tvalid && !m_axis_tready);
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur_l <= job.left;
            cur_r <= job.right;
            if (job.prime) begin
              prev_l <= job.left;
              prev_r <= job.right;
              pos    <= '0;
            end else if (pos_ge_one) begin
              // Step already carried past this frame: it yields no output.
              prev_l <= job.left;
              prev_r <= job.right;
              pos    <= pos - ONE_POS;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_l <= PROD_W'($signed(DIFF_W'(cur_l) - DIFF_W'(prev_l)))
                    * $signed(PROD_W'({1'b0, pos[FRAC_BITS-1:0]}));
          prod_r <= PROD_W'($signed(DIFF_W'(cur_r) - DIFF_W'(prev_r)))
                    * $signed(PROD_W'({1'b0, pos[FRAC_BITS-1:0]}));
          last   <= (pos_sum >= ONE_POS);
          pos    <= pos_sum;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) begin
            if (last) begin
              prev_l <= cur_l;
              prev_r <= cur_r;
              pos    <= pos - ONE_POS;
              state  <= ST_IDLE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_l        <= sum_l[SAMPLE_BITS-1:0];
      out_r        <= sum_r[SAMPLE_BITS-1:0];
      m_axis_tlast <= last;
    end
  end

  a_mul_frac_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> !pos_ge_one)
    else $error("interpolation started with position at or above one");

  a_emit_last_matches_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (last == pos_ge_one))
    else $error("last flag disagrees with the advanced position");

  a_prime_clears_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && job_valid && job.prime) |=> (pos == '0))
    else $error("priming frame did not clear the position");

  a_idle_pos_below_step_bound: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_IDLE) |-> (pos < POS_W'(step)))
    else $error("position after a run exceeds the step");

endmodule

`default_nettype wire

>>> design/stereo_linear_resampler_unit.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_unit: stereo linear-interpolation resampler
// Frames enter a two-deep job queue; the engine emits the interpolated
// samples of each frame through an output register.
// ----------------------------------------------------------------------------
// A frame's first output passes, after its beat is accepted, through
// dispatch from the queue, the multiply and the output register.
// The engine alternates a multiply step and an emit step for each output,
// holds in the emit step under back-pressure and takes a new frame only
// when idle. Priming frames and frames with no output are handled in idle.
// Reset (rst, synchronous) empties the queue, clears the previous frame and
// position, marks the block unprimed and sets the step to 1.0.
`default_nettype none

module stereo_linear_resampler_unit
  import slr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [STEP_W-1:0]        cfg_wdata,     // step_ratio
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [2*SAMPLE_BITS-1:0] s_axis_tdata,  // left_in, right_in
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [2*SAMPLE_BITS-1:0]      m_axis_tdata,  // left_out, right_out
  output logic                          m_axis_tlast   // last_of_run
);

  logic [STEP_W-1:0] step_ratio;
  logic [STEP_W-1:0] step_eff;
  logic              job_valid;
  logic              job_pop;
  slr_job_t          job;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= STEP_RESET;
    end else if (cfg_we) begin
      step_ratio <= cfg_wdata;
    end
  end

  // Zero stands for 1.0, and tiny steps are held at the 1/64 floor.
  always_comb begin
    if (step_ratio == '0) begin
      step_eff = ONE_STEP;
    end else if (step_ratio < MIN_STEP) begin
      step_eff = MIN_STEP;
    end else begin
      step_eff = step_ratio;
    end
  end

  slr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop)
  );

  slr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .step          (step_eff),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> tb/stereo_resample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_resample_checker: output predictor and scoreboard for the resampler
// Follows step writes and accepted input frames, works out the interpolated
// stereo samples each frame should produce, and compares every output beat
// against the oldest one still waiting.
// ----------------------------------------------------------------------------

module stereo_resample_checker
  import slr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [STEP_W-1:0]        cfg_wdata,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [2*SAMPLE_BITS-1:0] s_axis_tdata,
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [2*SAMPLE_BITS-1:0] m_axis_tdata,
  input  logic                     m_axis_tlast,
  output int                       mismatches,
  output int                       samples_pending
);

  localparam int MAX_RUN = 64;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    last;
  } stereo_sample_t;

  stereo_sample_t    expected_samples[$];
  sample_t           prev_left;
  sample_t           prev_right;
  logic [POS_W-1:0]  read_pos;
  logic              primed;
  logic [STEP_W-1:0] step_ratio;

  // Floor of the scaled difference: an arithmetic shift of the full product.
  function automatic sample_t interpolate(sample_t a, sample_t b,
                                          logic [FRAC_BITS-1:0] frac);
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    diff = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
    prod = diff * $signed({1'b0, frac});
    prod = prod >>> FRAC_BITS;
    return sample_t'(a + prod[SAMPLE_BITS-1:0]);
  endfunction

  task automatic report_mismatch(input string what, input stereo_sample_t want,
                                 input stereo_sample_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
               $realtime, what, want.left, want.right, want.last,
               got.left, got.right, got.last);
    end
  endtask

  always @(posedge clk) begin : predict
    stereo_sample_t    got;
    stereo_sample_t    want;
    stereo_sample_t    nxt;
    sample_t           cur_left;
    sample_t           cur_right;
    logic [STEP_W-1:0] step;
    int                n;
    if (rst) begin
      expected_samples.delete();
      prev_left  = '0;
      prev_right = '0;
      read_pos   = '0;
      primed     = 1'b0;
      step_ratio = STEP_RESET;
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.left  = m_axis_tdata[SAMPLE_BITS-1:0];
        got.right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        got.last  = m_axis_tlast;
        if (expected_samples.size() == 0) begin
          want.left  = '0;
          want.right = '0;
          want.last  = 1'b0;
          report_mismatch("output beat with nothing expected", want, got);
        end else begin
          want = expected_samples.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.last !== want.last) begin
            report_mismatch("output mismatch", want, got);
          end
        end
      end

      if (cfg_we) begin
        step_ratio = cfg_wdata;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        cur_left  = s_axis_tdata[SAMPLE_BITS-1:0];
        cur_right = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        if (!primed) begin
          primed   = 1'b1;
          read_pos = '0;
        end else begin
          if (step_ratio == '0) begin
            step = ONE_STEP;
          end else if (step_ratio < MIN_STEP) begin
            step = MIN_STEP;
          end else begin
            step = step_ratio;
          end
          n = 0;
          while (read_pos < ONE_POS && n < MAX_RUN) begin
            nxt.left  = interpolate(prev_left, cur_left, read_pos[FRAC_BITS-1:0]);
            nxt.right = interpolate(prev_right, cur_right, read_pos[FRAC_BITS-1:0]);
            read_pos  = read_pos + step;
            n++;
            nxt.last  = (read_pos >= ONE_POS) || (n == MAX_RUN);
            expected_samples.push_back(nxt);
          end
          read_pos = read_pos - ONE_POS;
        end
        prev_left  = cur_left;
        prev_right = cur_right;
      end
    end
    samples_pending = expected_samples.size();
  end

endmodule

>>> tb/tb_stereo_linear_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_linear_resampler_unit: testbench of the stereo resampler
// Drives directed and random stereo frames under a range of step settings,
// with bursty input traffic and an output side that stalls, including one
// long hold-off that backs the block up. A separate checker scores outputs.
// ----------------------------------------------------------------------------

module tb_stereo_linear_resampler_unit;
  import slr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 16;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [STEP_W-1:0]        cfg_wdata;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [2*SAMPLE_BITS-1:0] s_axis_tdata;   // left_in, right_in
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [2*SAMPLE_BITS-1:0] m_axis_tdata;   // left_out, right_out
  logic                     m_axis_tlast;   // last_of_run

  int mismatches;
  int samples_pending;
  int cycle_count;
  int burst_left;
  int hold_requests;
  int holds_served;
  int hold_left;
  int rx_mode;
  int rx_mode_left;

  stereo_linear_resampler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  stereo_resample_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .mismatches      (mismatches),
    .samples_pending (samples_pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: stall patterns that change every so often, plus a long
  // hold-off each time the stimulus asks for one.
  initial begin
    m_axis_tready = 1'b0;
    holds_served  = 0;
    hold_left     = 0;
    rx_mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = $urandom_range(0, 1);
          2:       m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = (rx_mode_left % 3 != 2);
        endcase
      end
    end
  end

  // Offers one frame, opening a new burst after a random gap when the
  // current one is used up. Valid stays high after the beat is taken.
  task automatic send_frame(input sample_t left, input sample_t right);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {right, left};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Frames that produce no output still pass through the engine after the
  // last expected sample has left, so allow a few more cycles.
  task automatic wait_drained();
    @(negedge clk);
    while (samples_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_step(input logic [STEP_W-1:0] value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin : stimulus
    sample_t           left;
    sample_t           right;
    logic [STEP_W-1:0] step;
    int                phase;
    int                i;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    hold_requests = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset step of 1.0: the first frame only primes, the rest give one each.
    send_frame(16'sh7FFF, -16'sh8000);
    send_frame(-16'sh8000, 16'sh7FFF);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(-16'sh0001, 16'sh0001);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(-16'sh8000, -16'sh8000);
    stop_sending();

    // Half step between full-scale swings exercises the floor on negatives.
    set_step(24'h008000);
    send_frame(16'sh7FFF, -16'sh8000);
    send_frame(-16'sh8000, 16'sh7FFF);
    send_frame(16'sh7FFF, -16'sh8000);
    send_frame(-16'sh0001, 16'sh0000);
    stop_sending();

    // Zero stands for a step of 1.0.
    set_step(24'h000000);
    send_frame(16'sh1234, -16'sh1234);
    send_frame(-16'sh4321, 16'sh4321);
    stop_sending();

    // Below the floor: runs of 64 samples per frame.
    set_step(24'h000001);
    send_frame(16'sh7FFF, -16'sh8000);
    send_frame(-16'sh8000, 16'sh7FFF);
    stop_sending();

    // Step of 1.5 gives at most one sample per frame, some frames none.
    set_step(24'h018000);
    send_frame(16'sh0100, -16'sh0100);
    send_frame(-16'sh0100, 16'sh0100);
    send_frame(16'sh7000, -16'sh7000);
    send_frame(16'sh0001, -16'sh0001);
    stop_sending();

    left  = '0;
    right = '0;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 1) begin
        step = $urandom_range(4 * MIN_STEP, 24'h002000);
      end else begin
        case ($urandom_range(0, 3))
          0:       step = $urandom_range(MIN_STEP, 24'h004000);
          1:       step = $urandom_range(24'h008000, 24'h020000);
          2:       step = $urandom_range(24'h020000, 24'h080000);
          default: step = $urandom_range(0, MIN_STEP - 1);
        endcase
      end
      set_step(step);
      if (phase == 1) begin
        @(posedge clk);
        hold_requests++;
      end
      for (i = 0; i < 11; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            left  = sample_t'($urandom);
            right = sample_t'($urandom);
          end
          1: begin
            left  = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            right = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
          end
          2: begin
            left  = left + sample_t'($urandom_range(0, 512)) - sample_t'(256);
            right = right + sample_t'($urandom_range(0, 512)) - sample_t'(256);
          end
          default: begin
            left  = sample_t'($urandom);
            right = -left;
          end
        endcase
        send_frame(left, right);
      end
      stop_sending();
    end

    // Largest step last: at most one of these frames gives a sample, the others none.
    set_step(24'hFFFFFF);
    send_frame(16'sh7FFF, -16'sh8000);
    send_frame(-16'sh8000, 16'sh7FFF);
    send_frame(16'sh5555, -16'sh5556);
    send_frame(-16'sh2AAB, 16'sh2AAA);
    stop_sending();

    wait_drained();
    if (mismatches == 0 && samples_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
design/slr_pkg.sv
design/slr_front.sv
design/slr_back.sv
design/stereo_linear_resampler_unit.sv
tb/stereo_resample_checker.sv
tb/tb_stereo_linear_resampler_unit.sv
